// ----- rtl/pbavg_pkg.sv -----
// ----------------------------------------------------------------------------
// pbavg_pkg
// Shared widths, default parameters and request/result types of the
// per-channel sample block averager.
// ----------------------------------------------------------------------------
package pbavg_pkg;

  // fixed field widths
  localparam int ChannelW = 3;
  localparam int SampleW  = 12;
  localparam int SumOutW  = 16;

  // number of channel codes the channel field can carry
  localparam int ChanSpan = 2 ** ChannelW;

  // width used to compare channel numbers against CHANNELS (up to 255)
  localparam int RangeW   = 8;

  // parameter defaults
  localparam int DefChannels   = 8;
  localparam int DefSamples    = 16;
  localparam int DefSampleBits = 12;

  typedef struct packed {
    logic [ChannelW-1:0] channel;
    logic                sample_ok;
    logic [SampleW-1:0]  sample;
  } in_item_t;

  typedef struct packed {
    logic [ChannelW-1:0] out_channel;
    logic [SumOutW-1:0]  block_sum;
    logic                frame_done;
  } out_item_t;

  // request from the input register to the accumulator bank
  typedef struct packed {
    logic     valid;   // item present in the input register
    logic     commit;  // item leaves the input register this cycle
    in_item_t item;
  } acc_req_t;

  // answer of the accumulator bank
  typedef struct packed {
    logic      emit;   // item completes a block
    out_item_t item;
  } acc_rsp_t;

endpackage

// ----- rtl/pbavg_if.sv -----
// ----------------------------------------------------------------------------
// pbavg_if
// Valid/ready channels of the block averager: sample input and block result.
// ----------------------------------------------------------------------------
interface pbavg_in_if import pbavg_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ChannelW-1:0] channel;
  logic                sample_ok;
  logic [SampleW-1:0]  sample;

  modport source (output valid, output channel, output sample_ok, output sample,
                  input ready);
  modport sink   (input valid, input channel, input sample_ok, input sample,
                  output ready);
endinterface

interface pbavg_out_if import pbavg_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ChannelW-1:0] out_channel;
  logic [SumOutW-1:0]  block_sum;
  logic                frame_done;

  modport source (output valid, output out_channel, output block_sum,
                  output frame_done, input ready);
  modport sink   (input valid, input out_channel, input block_sum,
                  input frame_done, output ready);
endinterface

// ----- rtl/pbavg_acc_bank.sv -----
// ----------------------------------------------------------------------------
// pbavg_acc_bank
// Per-channel running sums and sample counts with in-place
// read-modify-write and block completion detect.
// ----------------------------------------------------------------------------
module pbavg_acc_bank import pbavg_pkg::*; #(
  parameter int CHANNELS    = DefChannels,
  parameter int SAMPLES     = DefSamples,
  parameter int SAMPLE_BITS = DefSampleBits
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  acc_req_t req_i,
  output acc_rsp_t rsp_o
);

  // only channels the channel field can address need a slot
  localparam int NumSlots = (CHANNELS < ChanSpan) ? CHANNELS : ChanSpan;
  localparam int SlotW    = (NumSlots > 1) ? $clog2(NumSlots) : 1;
  localparam int EffBits  = (SAMPLE_BITS < SampleW) ? SAMPLE_BITS : SampleW;
  localparam int CntW     = $clog2(SAMPLES);
  localparam int SumW     = EffBits + CntW;

  logic [SumW-1:0] sum_q [NumSlots];
  logic [CntW-1:0] cnt_q [NumSlots];

  logic             in_range;
  logic             hit;
  logic [SlotW-1:0] slot;
  logic [SumW-1:0]  sum_new;
  logic             last;
  logic [SumOutW-1:0] sum_out;

  assign in_range = RangeW'(req_i.item.channel) < RangeW'(CHANNELS);
  assign hit      = req_i.valid && req_i.item.sample_ok && in_range;
  assign slot     = hit ? req_i.item.channel[SlotW-1:0] : '0;
  assign sum_new  = sum_q[slot] + SumW'(req_i.item.sample[EffBits-1:0]);
  assign last     = cnt_q[slot] == CntW'(SAMPLES - 1);

  generate
    if (SumW > SumOutW) begin : g_sat
      assign sum_out = (|sum_new[SumW-1:SumOutW]) ? '1 : sum_new[SumOutW-1:0];
    end else begin : g_nosat
      assign sum_out = SumOutW'(sum_new);
    end
  endgenerate

  assign rsp_o.emit             = hit && last;
  assign rsp_o.item.out_channel = req_i.item.channel;
  assign rsp_o.item.block_sum   = sum_out;
  assign rsp_o.item.frame_done  =
    RangeW'(req_i.item.channel) == RangeW'(CHANNELS - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumSlots; i++) begin
        sum_q[i] <= '0;
        cnt_q[i] <= '0;
      end
    end else if (req_i.commit && hit) begin
      if (last) begin
        sum_q[slot] <= '0;
        cnt_q[slot] <= '0;
      end else begin
        sum_q[slot] <= sum_new;
        cnt_q[slot] <= cnt_q[slot] + CntW'(1);
      end
    end
  end

endmodule

// ----- rtl/pbavg_out_stage.sv -----
// ----------------------------------------------------------------------------
// pbavg_out_stage
// Result register driving the block result channel.
// ----------------------------------------------------------------------------
module pbavg_out_stage import pbavg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  out_item_t   item_i,
  output logic        free_o,
  pbavg_out_if.source out_o
);

  logic      valid_q;
  out_item_t item_q;

  // register may take a new result when empty or being drained
  assign free_o = !valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && free_o) begin
      item_q <= item_i;
    end
  end

  assign out_o.valid       = valid_q;
  assign out_o.out_channel = item_q.out_channel;
  assign out_o.block_sum   = item_q.block_sum;
  assign out_o.frame_done  = item_q.frame_done;

endmodule

// ----- rtl/per_channel_sample_block_averager.sv -----
// ----------------------------------------------------------------------------
// per_channel_sample_block_averager
// Multichannel block average decimator: per-channel sums of SAMPLES good
// converter readings, one block sum out per completed channel block.
// ----------------------------------------------------------------------------
// usage
//   in_i  : sample requests (channel, sample_ok, sample), valid/ready
//   out_o : block results (out_channel, block_sum, frame_done), valid/ready
//   a request with sample_ok low or a channel of CHANNELS or more is taken
//   and dropped; every SAMPLES-th good request of a channel yields one
//   result carrying that channel's sum (average times SAMPLES, i.e. fixed
//   point with log2(SAMPLES) fraction bits), saturated at 65535
//   frame_done marks the result of channel CHANNELS-1
// timing
//   one request per cycle while no finishing request is stalled; a result
//   passes the input register, then the result register
//   the per-channel sum and count update is one read-modify-write while the
//   request sits in the input register, so back-to-back requests to the
//   same channel need no forwarding
// reset
//   all sums and counts clear, both registers empty
// stalls
//   while the result register holds an untaken result, requests that do
//   not finish a block keep flowing; a finishing request waits in the
//   input register and in_i.ready drops until out_o.ready frees the slot
// ----------------------------------------------------------------------------
module per_channel_sample_block_averager import pbavg_pkg::*; #(
  parameter int CHANNELS    = DefChannels,
  parameter int SAMPLES     = DefSamples,
  parameter int SAMPLE_BITS = DefSampleBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  pbavg_in_if.sink    in_i,
  pbavg_out_if.source out_o
);

  // input register
  logic     in_valid_q;
  logic     in_valid_d;
  in_item_t in_q;

  // stage control
  logic     accept;     // request taken at this edge
  logic     advance;    // input register item is processed this cycle
  logic     out_free;   // result register can take a result
  acc_req_t acc_req;
  acc_rsp_t acc_rsp;

  // an item without a result never waits for the output side
  assign advance = in_valid_q && (!acc_rsp.emit || out_free);
  assign in_i.ready = !in_valid_q || advance;
  assign accept = in_i.valid && in_i.ready;
  assign in_valid_d = accept || (in_valid_q && !advance);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q.channel   <= in_i.channel;
      in_q.sample_ok <= in_i.sample_ok;
      in_q.sample    <= in_i.sample;
    end
  end

  // per-channel accumulate, count and block detect
  assign acc_req.valid  = in_valid_q;
  assign acc_req.commit = advance;
  assign acc_req.item   = in_q;

  pbavg_acc_bank #(
    .CHANNELS   (CHANNELS),
    .SAMPLES    (SAMPLES),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_acc_bank (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (acc_req),
    .rsp_o (acc_rsp)
  );

  // result register
  pbavg_out_stage u_out_stage (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .load_i(advance && acc_rsp.emit),
    .item_i(acc_rsp.item),
    .free_o(out_free),
    .out_o (out_o)
  );

  // a stalled item stays in the input register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q)
    else $error("input register item lost while stalled");

  // a finished block always shows up as a result next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && acc_rsp.emit |=> out_o.valid)
    else $error("completed block did not reach the result register");

  // no result is pushed onto one still waiting to be taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |-> !(advance && acc_rsp.emit))
    else $error("result overwritten while output stalled");

  // frame done only ever flags the last channel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.frame_done |->
      RangeW'(out_o.out_channel) == RangeW'(CHANNELS - 1))
    else $error("frame done on a channel other than the last");

endmodule
